// ----- sv/amgd_pkg.sv -----
`timescale 1ns / 1ps

package amgd_pkg;

  // Motion state codes
  localparam logic [1:0] MOTION_STILL  = 2'd0;
  localparam logic [1:0] MOTION_PICKUP = 2'd1;
  localparam logic [1:0] MOTION_SHAKE  = 2'd2;
  localparam logic [1:0] MOTION_THROW  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_COUNT_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_ERROR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_WINDOW_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_COUNT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THROW_THRESHOLD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THROW_COUNT_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS        = 3'd7;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  RST_STILL_COUNT_LIMIT  = 8'd25;
  localparam logic [7:0]  RST_STILL_ERROR_LIMIT  = 8'd5;
  localparam logic [15:0] RST_SHAKE_THRESHOLD    = 16'd8192;
  localparam logic [7:0]  RST_SHAKE_WINDOW_LIMIT = 8'd10;
  localparam logic [7:0]  RST_SHAKE_COUNT_LIMIT  = 8'd3;
  localparam logic [15:0] RST_THROW_THRESHOLD    = 16'd2048;
  localparam logic [7:0]  RST_THROW_COUNT_LIMIT  = 8'd10;
  localparam logic [15:0] RST_COOLDOWN_MS        = 16'd2000;

  // 1 g = 4096 LSB; windows are exclusive bounds
  localparam logic [15:0] IN_WIN_LO   = 16'd3850; // 0.94 g
  localparam logic [15:0] IN_WIN_HI   = 16'd4301; // 1.05 g
  localparam logic [15:0] NEAR_WIN_LO = 16'd3604; // 0.88 g
  localparam logic [15:0] NEAR_WIN_HI = 16'd4588; // 1.12 g

  typedef struct packed {
    logic [15:0] accel_mag;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0] motion_state;
    logic       is_still;
    logic       shake_flag;
    logic       throw_flag;
    logic       shake_event;
    logic       throw_event;
  } result_t;

  typedef struct packed {
    logic [7:0]  still_count_limit;
    logic [7:0]  still_error_limit;
    logic [15:0] shake_threshold;
    logic [7:0]  shake_window_limit;
    logic [7:0]  shake_count_limit;
    logic [15:0] throw_threshold;
    logic [7:0]  throw_count_limit;
    logic [15:0] cooldown_ms;
  } cfg_t;

endpackage

// ----- sv/amgd_cfg.sv -----
`timescale 1ns / 1ps

module amgd_cfg
  import amgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.still_count_limit  <= RST_STILL_COUNT_LIMIT;
      cfg.still_error_limit  <= RST_STILL_ERROR_LIMIT;
      cfg.shake_threshold    <= RST_SHAKE_THRESHOLD;
      cfg.shake_window_limit <= RST_SHAKE_WINDOW_LIMIT;
      cfg.shake_count_limit  <= RST_SHAKE_COUNT_LIMIT;
      cfg.throw_threshold    <= RST_THROW_THRESHOLD;
      cfg.throw_count_limit  <= RST_THROW_COUNT_LIMIT;
      cfg.cooldown_ms        <= RST_COOLDOWN_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STILL_COUNT_LIMIT:  cfg.still_count_limit  <= cfg_wdata[7:0];
        CFG_STILL_ERROR_LIMIT:  cfg.still_error_limit  <= cfg_wdata[7:0];
        CFG_SHAKE_THRESHOLD:    cfg.shake_threshold    <= cfg_wdata;
        CFG_SHAKE_WINDOW_LIMIT: cfg.shake_window_limit <= cfg_wdata[7:0];
        CFG_SHAKE_COUNT_LIMIT:  cfg.shake_count_limit  <= cfg_wdata[7:0];
        CFG_THROW_THRESHOLD:    cfg.throw_threshold    <= cfg_wdata;
        CFG_THROW_COUNT_LIMIT:  cfg.throw_count_limit  <= cfg_wdata[7:0];
        CFG_COOLDOWN_MS:        cfg.cooldown_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/amgd_core.sv -----
`timescale 1ns / 1ps

module amgd_core
  import amgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  sample_t item,
  output result_t res
);

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

  logic [1:0]             motion_reg, motion_reg_next;
  logic                   still_flag, still_flag_next;
  logic                   shake_seen, shake_seen_next;
  logic                   throw_seen, throw_seen_next;
  logic [COUNT_WIDTH-1:0] still_counter, still_counter_next;
  logic [COUNT_WIDTH-1:0] near_error_counter, near_error_counter_next;
  logic [COUNT_WIDTH-1:0] shake_hits, shake_hits_next;
  logic [COUNT_WIDTH-1:0] shake_window, shake_window_next;
  logic [COUNT_WIDTH-1:0] throw_counter, throw_counter_next;
  logic [31:0]            last_shake_ms, last_shake_ms_next;
  logic [31:0]            last_throw_ms, last_throw_ms_next;

  logic [COUNT_WIDTH-1:0] sc_inc, ne_inc, hits_inc, win_inc, tc_inc;
  logic                   in_win, near_win, hi, lo, win_open;
  logic [31:0]            shake_age, throw_age;
  logic                   shake_cool_ok, throw_cool_ok;
  logic [1:0]             m_still, m_pick, m_shake;
  logic                   shake_ev, throw_ev;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign sc_inc   = sat_inc(still_counter);
  assign ne_inc   = sat_inc(near_error_counter);
  assign hits_inc = sat_inc(shake_hits);
  assign win_inc  = sat_inc(shake_window);
  assign tc_inc   = sat_inc(throw_counter);

  assign in_win   = (item.accel_mag > IN_WIN_LO) && (item.accel_mag < IN_WIN_HI);
  assign near_win = (item.accel_mag > NEAR_WIN_LO) && (item.accel_mag < NEAR_WIN_HI);
  assign hi       = item.accel_mag > cfg.shake_threshold;
  assign lo       = item.accel_mag < cfg.throw_threshold;
  assign win_open = CMP_W'(shake_window) < CMP_W'(cfg.shake_window_limit);

  // Wrapping age since the last reported event
  assign shake_age     = item.time_ms - last_shake_ms;
  assign throw_age     = item.time_ms - last_throw_ms;
  assign shake_cool_ok = shake_age >= {16'd0, cfg.cooldown_ms};
  assign throw_cool_ok = throw_age >= {16'd0, cfg.cooldown_ms};

  always_comb begin
    still_counter_next      = still_counter;
    near_error_counter_next = near_error_counter;
    still_flag_next         = still_flag;
    shake_hits_next         = shake_hits;
    shake_window_next       = shake_window;
    shake_seen_next         = shake_seen;
    throw_counter_next      = throw_counter;
    throw_seen_next         = throw_seen;
    last_shake_ms_next      = last_shake_ms;
    last_throw_ms_next      = last_throw_ms;
    m_still                 = motion_reg;
    shake_ev                = 1'b0;
    throw_ev                = 1'b0;

    // Still decision
    if (in_win) begin
      if (CMP_W'(sc_inc) >= CMP_W'(cfg.still_count_limit)) begin
        still_counter_next      = CNT_ZERO;
        near_error_counter_next = CNT_ZERO;
        still_flag_next         = 1'b1;
        m_still                 = MOTION_STILL;
      end else begin
        still_counter_next = sc_inc;
      end
    end else if (near_win) begin
      if (CMP_W'(ne_inc) > CMP_W'(cfg.still_error_limit)) begin
        still_counter_next      = CNT_ZERO;
        near_error_counter_next = CNT_ZERO;
        still_flag_next         = 1'b0;
      end else begin
        near_error_counter_next = ne_inc;
        still_counter_next      = sc_inc;
      end
    end else begin
      still_counter_next      = CNT_ZERO;
      near_error_counter_next = CNT_ZERO;
      still_flag_next         = 1'b0;
    end

    // Pickup: was still, no longer still
    m_pick = (m_still == MOTION_STILL && !still_flag_next) ? MOTION_PICKUP : m_still;

    // Shake
    m_shake = m_pick;
    if (hi && win_open) begin
      if (CMP_W'(hits_inc) >= CMP_W'(cfg.shake_count_limit)) begin
        shake_hits_next   = CNT_ZERO;
        shake_window_next = CNT_ZERO;
        shake_seen_next   = 1'b1;
        m_shake           = MOTION_SHAKE;
        if (shake_cool_ok) begin
          shake_ev           = 1'b1;
          last_shake_ms_next = item.time_ms;
        end
      end else begin
        shake_hits_next   = hits_inc;
        shake_window_next = win_inc;
      end
    end else if (win_open && shake_hits != CNT_ZERO) begin
      shake_window_next = win_inc;
      shake_seen_next   = 1'b0;
    end else begin
      shake_hits_next   = CNT_ZERO;
      shake_window_next = CNT_ZERO;
    end

    // Throw
    motion_reg_next = m_shake;
    if (lo) begin
      if (CMP_W'(tc_inc) >= CMP_W'(cfg.throw_count_limit)) begin
        throw_counter_next = CNT_ZERO;
        throw_seen_next    = 1'b1;
        motion_reg_next    = MOTION_THROW;
        if (throw_cool_ok) begin
          throw_ev           = 1'b1;
          last_throw_ms_next = item.time_ms;
        end
      end else begin
        throw_counter_next = tc_inc;
      end
    end else begin
      throw_counter_next = CNT_ZERO;
      throw_seen_next    = 1'b0;
    end
  end

  assign res.motion_state = motion_reg_next;
  assign res.is_still     = still_flag_next;
  assign res.shake_flag   = shake_seen_next;
  assign res.throw_flag   = throw_seen_next;
  assign res.shake_event  = shake_ev;
  assign res.throw_event  = throw_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_reg         <= MOTION_STILL;
      still_flag         <= 1'b0;
      shake_seen         <= 1'b0;
      throw_seen         <= 1'b0;
      still_counter      <= CNT_ZERO;
      near_error_counter <= CNT_ZERO;
      shake_hits         <= CNT_ZERO;
      shake_window       <= CNT_ZERO;
      throw_counter      <= CNT_ZERO;
      last_shake_ms      <= 32'd0;
      last_throw_ms      <= 32'd0;
    end else if (step) begin
      motion_reg         <= motion_reg_next;
      still_flag         <= still_flag_next;
      shake_seen         <= shake_seen_next;
      throw_seen         <= throw_seen_next;
      still_counter      <= still_counter_next;
      near_error_counter <= near_error_counter_next;
      shake_hits         <= shake_hits_next;
      shake_window       <= shake_window_next;
      throw_counter      <= throw_counter_next;
      last_shake_ms      <= last_shake_ms_next;
      last_throw_ms      <= last_throw_ms_next;
    end
  end

endmodule

// ----- sv/accel_motion_gesture_detector.sv -----
// Flow: a request taken waits in the input register, and its result is loaded
//   into the result register as it leaves, once the result register advances.
// Throughput: one request per clock unless the result side stalls; a sample's
//   update sits in the single combinational pass between the two registers.
// Reset (rst, synchronous): clears all counters, flags, event times and
//   valid bits, and restores every configuration register to its default.
`timescale 1ns / 1ps

module accel_motion_gesture_detector
  import amgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  logic    s1_valid;
  sample_t s1_item;
  logic    advance;
  logic    step;
  result_t core_res;

  // The result register moves on whenever it is empty or being taken.
  assign advance = !result_valid || !result_stall;
  // Hold the input side only when the input register is full and blocked.
  assign sample_stall = s1_valid && !advance;
  // Commit the state of the sample in the input register as it leaves.
  assign step = s1_valid && advance;

  amgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  amgd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (s1_item),
    .res  (core_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      s1_item <= sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_res;
    end
  end

endmodule

// ----- sv/amgd_chk.sv -----
`timescale 1ns / 1ps

module amgd_chk
  import amgd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A reported shake sets the flag and leaves the state shaken or thrown.
  a_shake_event: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.shake_event |->
      result.shake_flag &&
      (result.motion_state == MOTION_SHAKE || result.motion_state == MOTION_THROW))
    else $error("shake event without shake state");

  // A reported throw sets the flag and leaves the state thrown.
  a_throw_event: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.throw_event |->
      result.throw_flag && result.motion_state == MOTION_THROW)
    else $error("throw event without throw state");

endmodule

bind accel_motion_gesture_detector amgd_chk u_amgd_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- dv/motion_checker.sv -----
`timescale 1ns / 1ps

module motion_checker
  import amgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  sample_t               sample,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending
);

  // still windows in 1/4096 g, bounds exclusive
  localparam logic [15:0] STILL_LO = 16'd3850;  // 0.94 g
  localparam logic [15:0] STILL_HI = 16'd4301;  // 1.05 g
  localparam logic [15:0] NEAR_LO  = 16'd3604;  // 0.88 g
  localparam logic [15:0] NEAR_HI  = 16'd4588;  // 1.12 g

  typedef logic [COUNT_WIDTH-1:0] count_t;

  cfg_t        limits;
  logic [1:0]  motion_q;
  logic        still_q, shake_q, throw_q;
  count_t      still_cnt, near_cnt, shake_hits, shake_win, throw_cnt;
  logic [31:0] last_shake, last_throw;

  result_t     expected_motion [$];
  result_t     want_r, next_r;
  int          results_seen;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Move the motion state; return 1 when a shake or throw passes its cooldown.
  function automatic bit report_motion(input logic [1:0] m, input logic [31:0] now);
    if (m == MOTION_STILL && motion_q == MOTION_STILL) return 1'b0;
    motion_q = m;
    if (m == MOTION_SHAKE) begin
      if (now - last_shake < {16'd0, limits.cooldown_ms}) return 1'b0;
      last_shake = now;
      return 1'b1;
    end
    if (m == MOTION_THROW) begin
      if (now - last_throw < {16'd0, limits.cooldown_ms}) return 1'b0;
      last_throw = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_gesture(input sample_t s, output result_t r);
    logic [15:0] a;
    logic [31:0] now;
    bit          shake_ev, throw_ev;
    a = s.accel_mag;
    now = s.time_ms;
    shake_ev = 1'b0;
    throw_ev = 1'b0;

    if (a > STILL_LO && a < STILL_HI) begin
      still_cnt = sat_inc(still_cnt);
      if (still_cnt >= limits.still_count_limit) begin
        still_cnt = '0;
        near_cnt = '0;
        still_q = 1'b1;
        void'(report_motion(MOTION_STILL, now));
      end
    end else if (a > NEAR_LO && a < NEAR_HI) begin
      near_cnt = sat_inc(near_cnt);
      if (near_cnt > limits.still_error_limit) begin
        still_cnt = '0;
        near_cnt = '0;
        still_q = 1'b0;
      end else begin
        still_cnt = sat_inc(still_cnt);
      end
    end else begin
      still_cnt = '0;
      near_cnt = '0;
      still_q = 1'b0;
    end

    if (motion_q == MOTION_STILL && !still_q) void'(report_motion(MOTION_PICKUP, now));

    if (a > limits.shake_threshold && shake_win < limits.shake_window_limit) begin
      shake_hits = sat_inc(shake_hits);
      shake_win = sat_inc(shake_win);
      if (shake_hits >= limits.shake_count_limit) begin
        shake_hits = '0;
        shake_win = '0;
        shake_q = 1'b1;
        shake_ev = report_motion(MOTION_SHAKE, now);
      end
    end else if (shake_win < limits.shake_window_limit && shake_hits != '0) begin
      shake_win = sat_inc(shake_win);
      shake_q = 1'b0;
    end else begin
      shake_hits = '0;
      shake_win = '0;
    end

    if (a < limits.throw_threshold) begin
      throw_cnt = sat_inc(throw_cnt);
      if (throw_cnt >= limits.throw_count_limit) begin
        throw_cnt = '0;
        throw_q = 1'b1;
        throw_ev = report_motion(MOTION_THROW, now);
      end
    end else begin
      throw_cnt = '0;
      throw_q = 1'b0;
    end

    r = '{motion_state: motion_q, is_still: still_q, shake_flag: shake_q,
          throw_flag: throw_q, shake_event: shake_ev, throw_event: throw_ev};
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
  end

  // Compare the result first: it always belongs to an older request than
  // one taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      limits = '{still_count_limit: RST_STILL_COUNT_LIMIT,
                 still_error_limit: RST_STILL_ERROR_LIMIT,
                 shake_threshold: RST_SHAKE_THRESHOLD,
                 shake_window_limit: RST_SHAKE_WINDOW_LIMIT,
                 shake_count_limit: RST_SHAKE_COUNT_LIMIT,
                 throw_threshold: RST_THROW_THRESHOLD,
                 throw_count_limit: RST_THROW_COUNT_LIMIT,
                 cooldown_ms: RST_COOLDOWN_MS};
      motion_q = MOTION_STILL;
      still_q = 1'b0;
      shake_q = 1'b0;
      throw_q = 1'b0;
      still_cnt = '0;
      near_cnt = '0;
      shake_hits = '0;
      shake_win = '0;
      throw_cnt = '0;
      last_shake = '0;
      last_throw = '0;
      expected_motion.delete();
      pending = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_motion.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing outstanding: state %0d", results_seen,
                     result.motion_state);
        end else begin
          want_r = expected_motion.pop_front();
          if (result.motion_state !== want_r.motion_state ||
              result.is_still !== want_r.is_still ||
              result.shake_flag !== want_r.shake_flag ||
              result.throw_flag !== want_r.throw_flag ||
              result.shake_event !== want_r.shake_event ||
              result.throw_event !== want_r.throw_event) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("result %0d mismatch: expected state %0d still %0b shake %0b/%0b ",
                     results_seen, want_r.motion_state, want_r.is_still,
                     want_r.shake_flag, want_r.shake_event);
              $display("throw %0b/%0b, got state %0d still %0b shake %0b/%0b throw %0b/%0b",
                       want_r.throw_flag, want_r.throw_event, result.motion_state,
                       result.is_still, result.shake_flag, result.shake_event,
                       result.throw_flag, result.throw_event);
            end
          end
        end
        results_seen++;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_STILL_COUNT_LIMIT:  limits.still_count_limit = cfg_wdata[7:0];
          CFG_STILL_ERROR_LIMIT:  limits.still_error_limit = cfg_wdata[7:0];
          CFG_SHAKE_THRESHOLD:    limits.shake_threshold = cfg_wdata;
          CFG_SHAKE_WINDOW_LIMIT: limits.shake_window_limit = cfg_wdata[7:0];
          CFG_SHAKE_COUNT_LIMIT:  limits.shake_count_limit = cfg_wdata[7:0];
          CFG_THROW_THRESHOLD:    limits.throw_threshold = cfg_wdata;
          CFG_THROW_COUNT_LIMIT:  limits.throw_count_limit = cfg_wdata[7:0];
          CFG_COOLDOWN_MS:        limits.cooldown_ms = cfg_wdata;
          default: ;
        endcase
      end

      if (sample_valid && !sample_stall) begin
        step_gesture(sample, next_r);
        expected_motion.push_back(next_r);
      end
      pending = expected_motion.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import amgd_pkg::*;

  localparam int COUNT_W     = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;     // result stall long enough to back up the block
  localparam int PHASE_REQS  = 24;
  localparam int SAT_RUN     = 280;     // near-window requests past counter saturation

  typedef enum {SET_TAME, SET_MAX, SET_MIN, SET_WILD, SET_DEFAULT} setting_e;
  typedef enum {RUN_STILL, RUN_NEAR, RUN_HIGH, RUN_LOW, RUN_NOISE} run_kind_e;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          mismatches;
  int          pending;
  int          cycles;
  cfg_t        cur_cfg;
  logic [31:0] clock_ms;
  bit          tx_bursty;
  bit          rx_bursty;
  bit          hold_off_req;

  accel_motion_gesture_detector #(.COUNT_WIDTH(COUNT_W)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  motion_checker #(.COUNT_WIDTH(COUNT_W)) i_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stop the run if it hangs anywhere.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: draw a stall per result, hold stall for that many cycles,
  // then take the next result. A pending hold-off request replaces the draw
  // with one long stretch so the block backs up and stalls its input.
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        n = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        n = rx_bursty ? 0 : $urandom_range(0, 17);
      end
      repeat (n) begin
        result_stall <= 1'b1;
        @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Offer one request after a drawn gap; hold it until taken. Valid stays
  // high across back-to-back requests.
  task automatic send_sample(input logic [15:0] mag, input logic [31:0] stamp);
    int gap;
    gap = tx_bursty ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    repeat (gap) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{accel_mag: mag, time_ms: stamp};
    do @(posedge clk); while (sample_stall);
  endtask

  // Drop valid and hold off until every expected result is back, then let
  // the two-stage pipeline settle.
  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all registers, one per cycle. Upper bits of the narrow registers
  // carry junk that the block must drop.
  task automatic write_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] data [8];
    for (int i = 0; i <= CFG_COOLDOWN_MS; i++) data[i] = CFG_DATA_W'($urandom);
    data[CFG_STILL_COUNT_LIMIT][7:0]  = c.still_count_limit;
    data[CFG_STILL_ERROR_LIMIT][7:0]  = c.still_error_limit;
    data[CFG_SHAKE_THRESHOLD]         = c.shake_threshold;
    data[CFG_SHAKE_WINDOW_LIMIT][7:0] = c.shake_window_limit;
    data[CFG_SHAKE_COUNT_LIMIT][7:0]  = c.shake_count_limit;
    data[CFG_THROW_THRESHOLD]         = c.throw_threshold;
    data[CFG_THROW_COUNT_LIMIT][7:0]  = c.throw_count_limit;
    data[CFG_COOLDOWN_MS]             = c.cooldown_ms;
    for (int i = 0; i <= CFG_COOLDOWN_MS; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= data[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t pick_config(input setting_e s);
    cfg_t        c;
    logic [95:0] wild;
    case (s)
      SET_TAME: begin
        // small limits so still, shake and throw decisions come often
        c.still_count_limit  = 8'($urandom_range(1, 8));
        c.still_error_limit  = 8'($urandom_range(0, 3));
        c.shake_threshold    = 16'($urandom_range(5000, 12000));
        c.shake_window_limit = 8'($urandom_range(1, 8));
        c.shake_count_limit  = 8'($urandom_range(1, 4));
        c.throw_threshold    = 16'($urandom_range(1000, 4000));
        c.throw_count_limit  = 8'($urandom_range(1, 6));
        c.cooldown_ms        = 16'($urandom_range(0, 300));
      end
      SET_MAX: c = '{still_count_limit: 8'hFF, still_error_limit: 8'hFF,
                     shake_threshold: 16'hFFFF, shake_window_limit: 8'hFF,
                     shake_count_limit: 8'hFF, throw_threshold: 16'hFFFF,
                     throw_count_limit: 8'hFF, cooldown_ms: 16'hFFFF};
      SET_MIN: c = '0;
      SET_WILD: begin
        wild = {$urandom, $urandom, $urandom};
        c = wild[$bits(cfg_t)-1:0];
      end
      default: c = '{still_count_limit: RST_STILL_COUNT_LIMIT,
                     still_error_limit: RST_STILL_ERROR_LIMIT,
                     shake_threshold: RST_SHAKE_THRESHOLD,
                     shake_window_limit: RST_SHAKE_WINDOW_LIMIT,
                     shake_count_limit: RST_SHAKE_COUNT_LIMIT,
                     throw_threshold: RST_THROW_THRESHOLD,
                     throw_count_limit: RST_THROW_COUNT_LIMIT,
                     cooldown_ms: RST_COOLDOWN_MS};
    endcase
    return c;
  endfunction

  // Magnitude of the given kind under the current thresholds.
  function automatic logic [15:0] pick_mag(input run_kind_e k);
    case (k)
      RUN_STILL: return 16'($urandom_range(3851, 4300));
      RUN_NEAR:  return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(3605, 3850))
                                                    : 16'($urandom_range(4301, 4587));
      RUN_HIGH:  return (cur_cfg.shake_threshold == 16'hFFFF) ? 16'hFFFF
                        : 16'($urandom_range(cur_cfg.shake_threshold + 1, 16'hFFFF));
      RUN_LOW:   return (cur_cfg.throw_threshold == 16'd0) ? 16'd0
                        : 16'($urandom_range(0, cur_cfg.throw_threshold - 1));
      default:   return 16'($urandom);
    endcase
  endfunction

  // Mostly short steps so cooldowns bite; now and then a jump or a
  // fresh timestamp anywhere in the 32-bit range.
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(0, 39))
      0:       clock_ms = $urandom;
      1, 2:    clock_ms = clock_ms + $urandom;
      default: clock_ms = clock_ms + $urandom_range(0, 150);
    endcase
    return clock_ms;
  endfunction

  task automatic send_run(input run_kind_e k, input int len);
    repeat (len) send_sample(pick_mag(k), next_stamp());
  endtask

  logic [15:0] dir_mags [19];
  setting_e    plan [8];
  run_kind_e   kind;
  int          sent;
  int          len;
  int          roll;

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    clock_ms = 32'hFFFF_FF00;  // directed part runs across the wrap
    tx_bursty = 1'b0;
    rx_bursty = 1'b0;
    hold_off_req = 1'b0;
    cur_cfg = pick_config(SET_DEFAULT);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: window edges, threshold edges, field extremes, with tight
    // limits so still, loss of still, pickup, shake and throw all show.
    write_config('{still_count_limit: 8'd2, still_error_limit: 8'd1,
                   shake_threshold: 16'd8192, shake_window_limit: 8'd3,
                   shake_count_limit: 8'd2, throw_threshold: 16'd2048,
                   throw_count_limit: 8'd2, cooldown_ms: 16'd100});
    dir_mags = '{16'd3851, 16'd4300, 16'd3850, 16'd4301, 16'd4588, 16'd3605, 16'd4587,
                 16'd0, 16'd2047, 16'd2048, 16'hFFFF, 16'd8193, 16'd8192, 16'hFFFF,
                 16'd1000, 16'hFFFF, 16'd0, 16'd0, 16'd4000};
    foreach (dir_mags[i]) begin
      send_sample(dir_mags[i], clock_ms);
      clock_ms = clock_ms + 32'd60;
    end
    send_sample(16'd4000, 32'hFFFF_FFFF);
    drain();

    // Crossed thresholds: one request can be both high and low, so shake
    // and throw report together and throw wins the state.
    write_config('{still_count_limit: 8'd1, still_error_limit: 8'd0,
                   shake_threshold: 16'd100, shake_window_limit: 8'd1,
                   shake_count_limit: 8'd1, throw_threshold: 16'd60000,
                   throw_count_limit: 8'd1, cooldown_ms: 16'd0});
    send_sample(16'd4000, 32'd0);
    send_sample(16'd101, 32'd5);
    send_sample(16'hFFFF, 32'd10);
    drain();

    // All-zero limits: first qualifying request meets each count, and a
    // zero shake window never lets a high request count.
    write_config(pick_config(SET_MIN));
    send_sample(16'd4000, 32'd20);
    send_sample(16'd3700, 32'd21);
    send_sample(16'hFFFF, 32'd22);
    drain();

    // Random phases, each under its own setting.
    plan = '{SET_TAME, SET_MAX, SET_TAME, SET_WILD, SET_MIN, SET_TAME, SET_WILD,
             SET_DEFAULT};
    foreach (plan[p]) begin
      write_config(pick_config(plan[p]));
      if (plan[p] == SET_MAX) begin
        // drive the still and near-miss counters into saturation
        tx_bursty = 1'b1;
        rx_bursty = 1'b1;
        send_run(RUN_NEAR, SAT_RUN);
      end
      if (p == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PHASE_REQS) begin
        tx_bursty = ($urandom_range(0, 3) == 0);
        rx_bursty = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 19);
        if (roll < 6)       kind = RUN_STILL;
        else if (roll < 9)  kind = RUN_NEAR;
        else if (roll < 14) kind = RUN_HIGH;
        else if (roll < 18) kind = RUN_LOW;
        else                kind = RUN_NOISE;
        len = $urandom_range(1, 12);
        send_run(kind, len);
        sent += len;
        // pause the sender once until the block has emptied
        if (p == 5 && sent >= PHASE_REQS / 2 && sent - len < PHASE_REQS / 2) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/amgd_pkg.sv
sv/amgd_cfg.sv
sv/amgd_core.sv
sv/accel_motion_gesture_detector.sv
sv/amgd_chk.sv
dv/motion_checker.sv
dv/testbench.sv
